// ===== rtl/core/bsslc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-spread line codec package
// Shared item and result types, line constants and the group spreading rule.
// ----------------------------------------------------------------------------
package bsslc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 10;
  localparam int unsigned StepW   = 4;

  localparam logic        OP_ENCODE = 1'b0;
  localparam logic        OP_DECODE = 1'b1;

  localparam logic [ByteW-1:0] LINE_IDLE = 8'hFF;
  localparam logic [ByteW-1:0] CHAR_CR   = 8'h0D;
  localparam logic [ByteW-1:0] CHAR_LF   = 8'h0A;
  localparam int unsigned      LowCarrierBit  = 2;
  localparam int unsigned      HighCarrierBit = 5;

  localparam logic [LenW-1:0]  MAX_LEN_RESET = 10'd512;

  // last encode step of a plain character and of a character with CR LF
  localparam logic [StepW-1:0] STEP_LAST_CHAR = 4'd3;
  localparam logic [StepW-1:0] STEP_LAST_TERM = 4'd11;

  typedef struct packed {
    logic             append_terminator;
    logic [ByteW-1:0] data;
    logic             op;
  } item_t;

  typedef struct packed {
    logic             last;
    logic             overflow;
    logic             end_of_line;
    logic             from_decoder;
    logic [ByteW-1:0] out_byte;
  } result_t;

  // Line byte for one bit pair: a zero payload bit clears its carrier bit.
  function automatic logic [ByteW-1:0] spread_pair(input logic [1:0] pair);
    logic [ByteW-1:0] b;
    b = LINE_IDLE;
    b[LowCarrierBit]  = pair[0];
    b[HighCarrierBit] = pair[1];
    return b;
  endfunction

endpackage

// ===== rtl/core/bit_spread_serial_line_codec_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-spread serial line codec
// Encodes characters into four line bytes each and decodes received line
// bytes back into characters with CR LF and message length checks.
// ----------------------------------------------------------------------------
// A request is held in an input register and its results leave through one
// output register, one result per cycle while the output is taken. An encode
// request yields four line bytes (twelve with append_terminator); a decode
// request holds one line byte; only every fourth line byte produces a result.
// A new request is taken in the cycle the held one finishes. A result waiting
// at the output stalls a held encode request and the fourth byte of a decode
// group until it is taken; the first three bytes of a group never stall.
// ----------------------------------------------------------------------------
module bit_spread_serial_line_codec_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [9:0] cfg_wr_data_i,   // max_message_length
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data
  input  logic [1:0] s_axis_tuser_i,  // [0] op, [1] append_terminator
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [2:0] m_axis_tuser_o,  // [0] from_decoder, [1] end_of_line, [2] overflow
  output logic       m_axis_tlast_o
);
  import bsslc_pkg::*;

  logic [LenW-1:0] max_len_q;
  logic            in_vld_q;
  item_t           in_item_q;
  logic            out_vld_q, out_vld_d;
  result_t         out_res_q;

  logic    is_enc, out_free, out_load, item_done;
  logic    enc_done, dec_complete;
  result_t enc_res, dec_res;

  assign is_enc   = (in_item_q.op == OP_ENCODE);
  assign out_free = !out_vld_q || m_axis_tready_i;

  bsslc_encoder u_enc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_i (in_vld_q && is_enc),
    .adv_i    (out_free),
    .data_i   (in_item_q.data),
    .term_i   (in_item_q.append_terminator),
    .res_o    (enc_res),
    .done_o   (enc_done)
  );

  bsslc_decoder u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .consume_i  (in_vld_q && !is_enc && item_done),
    .data_i     (in_item_q.data),
    .max_len_i  (max_len_q),
    .complete_o (dec_complete),
    .res_o      (dec_res)
  );

  // partial decode groups finish without touching the output
  assign item_done = in_vld_q && (is_enc ? enc_done : (!dec_complete || out_free));
  assign out_load  = in_vld_q && out_free && (is_enc || dec_complete);
  assign s_axis_tready_o = !in_vld_q || item_done;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        max_len_q <= cfg_wr_data_i;
      end
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q.op                <= s_axis_tuser_i[0];
      in_item_q.append_terminator <= s_axis_tuser_i[1];
      in_item_q.data              <= s_axis_tdata_i;
    end
    if (out_load) begin
      out_res_q <= is_enc ? enc_res : dec_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_res_q.out_byte;
  assign m_axis_tuser_o  = {out_res_q.overflow, out_res_q.end_of_line,
                            out_res_q.from_decoder};
  assign m_axis_tlast_o  = out_res_q.last;

`ifndef SYNTHESIS
  a_enc_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_res_q.from_decoder |-> !out_res_q.end_of_line && !out_res_q.overflow)
    else $error("encoded line byte carries decoder flags");

  a_eol_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_res_q.end_of_line && out_res_q.overflow))
    else $error("end of line and overflow both set");

  a_dec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.from_decoder |-> out_res_q.last)
    else $error("decoded character not marked last");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !item_done |=> in_vld_q && $stable(in_item_q))
    else $error("held request lost before it finished");
`endif

endmodule

// ===== rtl/core/bsslc_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-spread line encoder
// Steps through the four line bytes of a character, plus CR and LF on request.
// ----------------------------------------------------------------------------
module bsslc_encoder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   active_i,
  input  logic                   adv_i,
  input  logic [7:0]             data_i,
  input  logic                   term_i,
  output bsslc_pkg::result_t     res_o,
  output logic                   done_o
);
  import bsslc_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] last_step;
  logic [ByteW-1:0] ch;
  logic [1:0]       pair;
  logic             at_last;

  assign last_step = term_i ? STEP_LAST_TERM : STEP_LAST_CHAR;
  assign at_last   = (step_q == last_step);
  assign done_o    = active_i && adv_i && at_last;

  always_comb begin
    case (step_q[3:2])
      2'd1:    ch = CHAR_CR;
      2'd2:    ch = CHAR_LF;
      default: ch = data_i;
    endcase
    case (step_q[1:0])
      2'd0:    pair = ch[1:0];
      2'd1:    pair = ch[3:2];
      2'd2:    pair = ch[5:4];
      default: pair = ch[7:6];
    endcase
  end

  always_comb begin
    res_o              = '0;
    res_o.out_byte     = spread_pair(pair);
    res_o.from_decoder = 1'b0;
    res_o.last         = at_last;
  end

  always_comb begin
    step_d = step_q;
    if (active_i && adv_i) begin
      step_d = at_last ? '0 : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/core/bsslc_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-spread line decoder
// Collects four line bytes into a character and tracks line end and length.
// ----------------------------------------------------------------------------
module bsslc_decoder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   consume_i,
  input  logic [7:0]             data_i,
  input  logic [9:0]             max_len_i,
  output logic                   complete_o,
  output bsslc_pkg::result_t     res_o
);
  import bsslc_pkg::*;

  logic [1:0]      pos_q, pos_d;
  logic [5:0]      part_q, part_d;
  logic            prev_cr_q, prev_cr_d;
  logic [LenW-1:0] msg_len_q, msg_len_d;

  logic [1:0]       pair;
  logic [ByteW-1:0] ch;
  logic [LenW:0]    len;
  logic             eol, ovf;

  assign pair       = {data_i[HighCarrierBit], data_i[LowCarrierBit]};
  assign ch         = {pair, part_q};
  assign len        = {1'b0, msg_len_q} + 11'd1;
  assign eol        = prev_cr_q && (ch == CHAR_LF);
  assign ovf        = !eol && (len > {1'b0, max_len_i});
  assign complete_o = (pos_q == 2'd3);

  always_comb begin
    res_o              = '0;
    res_o.out_byte     = ch;
    res_o.from_decoder = 1'b1;
    res_o.end_of_line  = eol;
    res_o.overflow     = ovf;
    res_o.last         = 1'b1;
  end

  always_comb begin
    pos_d     = pos_q;
    part_d    = part_q;
    prev_cr_d = prev_cr_q;
    msg_len_d = msg_len_q;
    if (consume_i) begin
      if (!complete_o) begin
        pos_d = pos_q + 2'd1;
        case (pos_q)
          2'd0:    part_d[1:0] = pair;
          2'd1:    part_d[3:2] = pair;
          default: part_d[5:4] = pair;
        endcase
      end else begin
        pos_d  = '0;
        part_d = '0;
        if (eol || ovf) begin
          msg_len_d = '0;
          prev_cr_d = 1'b0;
        end else begin
          msg_len_d = len[LenW-1:0];
          prev_cr_d = (ch == CHAR_CR);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      part_q    <= '0;
      prev_cr_q <= 1'b0;
      msg_len_q <= '0;
    end else begin
      pos_q     <= pos_d;
      part_q    <= part_d;
      prev_cr_q <= prev_cr_d;
      msg_len_q <= msg_len_d;
    end
  end

endmodule
